// ===== hw/rtl/p2s_pkg.sv =====
// Shared constants, register codes and the CORDIC arctangent table of the plate transform.
package p2s_pkg;

  localparam int unsigned CordIters = 20;
  localparam int unsigned CordW     = 33;
  localparam int unsigned AngW      = 29;

  localparam logic signed [CordW-1:0] CordGain = 33'sd652032874;

  localparam logic signed [26:0] FullCircle    = 27'sd23592960;
  localparam logic signed [26:0] HalfCircle    = 27'sd11796480;
  localparam logic signed [26:0] QuarterCircle = 27'sd5898240;

  localparam int PoleLimit = 93323264;

  typedef enum logic [2:0] {
    RegCenterX  = 3'd0,
    RegCenterY  = 3'd1,
    RegRotation = 3'd2,
    RegScaleX   = 3'd3,
    RegScaleY   = 3'd4,
    RegTargetRa = 3'd5,
    RegTargetDe = 3'd6,
    RegFlip     = 3'd7
  } cfg_reg_e;

  function automatic logic signed [AngW-1:0] atan_q20(input int unsigned idx);
    logic signed [AngW-1:0] val;
    case (idx)
      0:       val = 29'sd47185920;
      1:       val = 29'sd27855475;
      2:       val = 29'sd14718068;
      3:       val = 29'sd7471121;
      4:       val = 29'sd3750058;
      5:       val = 29'sd1876857;
      6:       val = 29'sd938658;
      7:       val = 29'sd469357;
      8:       val = 29'sd234682;
      9:       val = 29'sd117342;
      10:      val = 29'sd58671;
      11:      val = 29'sd29335;
      12:      val = 29'sd14668;
      13:      val = 29'sd7334;
      14:      val = 29'sd3667;
      15:      val = 29'sd1833;
      16:      val = 29'sd917;
      17:      val = 29'sd458;
      18:      val = 29'sd229;
      19:      val = 29'sd115;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/p2s_cordic_cell.sv =====
// One rotation-mode CORDIC iteration, registered, with side payload carried along.
module p2s_cordic_cell #(
  parameter int unsigned Iter  = 0,
  parameter int unsigned SideW = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [p2s_pkg::CordW-1:0]  x_i,
  input  logic signed [p2s_pkg::CordW-1:0]  y_i,
  input  logic signed [p2s_pkg::AngW-1:0]   z_i,
  input  logic        [SideW-1:0]           side_i,
  output logic                              valid_o,
  output logic signed [p2s_pkg::CordW-1:0]  x_o,
  output logic signed [p2s_pkg::CordW-1:0]  y_o,
  output logic signed [p2s_pkg::AngW-1:0]   z_o,
  output logic        [SideW-1:0]           side_o
);

  logic signed [p2s_pkg::CordW-1:0] xs, ys;
  logic signed [p2s_pkg::AngW-1:0]  at;

  assign xs = x_i >>> Iter;
  assign ys = y_i >>> Iter;
  assign at = p2s_pkg::atan_q20(Iter);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      if (!z_i[p2s_pkg::AngW-1]) begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - at;
      end else begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + at;
      end
    end
  end

endmodule

// ===== hw/rtl/p2s_div_cell.sv =====
// One restoring division step per lane: shift in a numerator bit, subtract when it fits.
module p2s_div_cell #(
  parameter int unsigned Lanes = 1,
  parameter int unsigned DivW  = 8,
  parameter int unsigned NumW  = 33,
  parameter int unsigned QuoW  = 33,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DivW-1:0]  div_i,
  input  logic [DivW-1:0]  rem_i [Lanes],
  input  logic [NumW-1:0]  num_i [Lanes],
  input  logic [QuoW-1:0]  quo_i [Lanes],
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [DivW-1:0]  div_o,
  output logic [DivW-1:0]  rem_o [Lanes],
  output logic [NumW-1:0]  num_o [Lanes],
  output logic [QuoW-1:0]  quo_o [Lanes],
  output logic [SideW-1:0] side_o
);

  logic [DivW:0]   trial [Lanes];
  logic [DivW:0]   diff  [Lanes];
  logic            fits  [Lanes];
  logic [DivW-1:0] rem_d [Lanes];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      trial[l] = {rem_i[l], num_i[l][NumW-1]};
      diff[l]  = trial[l] - {1'b0, div_i};
      fits[l]  = trial[l] >= {1'b0, div_i};
      rem_d[l] = fits[l] ? diff[l][DivW-1:0] : trial[l][DivW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_o  <= div_i;
      side_o <= side_i;
      for (int l = 0; l < Lanes; l++) begin
        rem_o[l] <= rem_d[l];
        num_o[l] <= {num_i[l][NumW-2:0], 1'b0};
        quo_o[l] <= {quo_i[l][QuoW-2:0], fits[l]};
      end
    end
  end

endmodule

// ===== hw/rtl/pixel_to_sky_coordinates_unit.sv =====
// Top level of the pixel to sky plate transform pipeline.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------------
//  s_*      | in  | s_tvalid_i/s_tready_o| s_tdata_i: pixel_x, pixel_y
//  m_*      | out | m_tvalid_o/m_tready_i| m_tdata_o: sky_ra, sky_dec; m_tuser_o
//  cfg_*    | in  | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// One beat per cycle while m_* is not stalled; the path runs through two 20-cell CORDIC rows,
// a three-stage reciprocal divide by 225 and a 38-cell secant divider.
// Reset clears all valid flags and loads the register reset values.
// The whole row advances together; when a result is held on m_*, it stalls and
// s_tready_o drops.
module pixel_to_sky_coordinates_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [39:0] s_tdata_i,   // [19:0] pixel_x, [39:20] pixel_y
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [63:0] m_tdata_o,   // [30:0] sky_ra, [61:31] sky_dec, [63:62] zero
  output logic        m_tuser_o,   // [0] near_pole
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [28:0] cfg_data_i
);

  localparam int unsigned Iters    = p2s_pkg::CordIters;
  localparam int unsigned CW       = p2s_pkg::CordW;
  localparam int unsigned AW       = p2s_pkg::AngW;
  localparam int unsigned RotSideW = 43;
  localparam int unsigned DecSideW = 65;
  localparam int unsigned DivBN    = 38;
  localparam int unsigned SecSideW = 66;

  localparam logic signed [54:0] Round14   = 55'sd8192;
  localparam logic signed [62:0] ScaleHalf = 63'sd117964800;
  localparam logic [28:0]        Recip225  = 29'd305419897;
  localparam logic [21:0]        Div225    = 22'd225;
  localparam logic signed [34:0] PoleLim   = 35'(p2s_pkg::PoleLimit);
  localparam logic signed [34:0] DecMax    = 35'sd1073741823;
  localparam logic signed [34:0] DecMin    = -35'sd1073741824;
  localparam logic signed [40:0] OutMax    = 41'sd1073741823;
  localparam logic signed [40:0] OutMin    = -41'sd1073741824;

  // configuration
  logic [19:0] cx_q, cy_q;
  logic [24:0] rot_q;
  logic [23:0] scx_q, scy_q;
  logic [28:0] tra_q;
  logic [27:0] tdec_q;
  logic        flip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      rot_q  <= '0;
      scx_q  <= 24'd65536;
      scy_q  <= 24'd65536;
      tra_q  <= '0;
      tdec_q <= '0;
      flip_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (p2s_pkg::cfg_reg_e'(cfg_idx_i))
        p2s_pkg::RegCenterX:  cx_q   <= cfg_data_i[19:0];
        p2s_pkg::RegCenterY:  cy_q   <= cfg_data_i[19:0];
        p2s_pkg::RegRotation: rot_q  <= cfg_data_i[24:0];
        p2s_pkg::RegScaleX:   scx_q  <= cfg_data_i[23:0];
        p2s_pkg::RegScaleY:   scy_q  <= cfg_data_i[23:0];
        p2s_pkg::RegTargetRa: tra_q  <= cfg_data_i;
        p2s_pkg::RegTargetDe: tdec_q <= cfg_data_i[27:0];
        p2s_pkg::RegFlip:     flip_q <= cfg_data_i[0];
      endcase
    end
  end

  logic en, acc;
  assign en         = !m_tvalid_o || m_tready_i;
  assign s_tready_o = en;
  assign acc        = s_tvalid_i && en;

  // angle folding and pixel offset
  logic signed [26:0] ang_a, ang_b, ang_c, ang_d;
  logic               ang_neg;
  logic signed [20:0] in_dx, in_dy;

  always_comb begin
    ang_a = 27'($signed(rot_q));
    ang_b = ang_a[26] ? ang_a + p2s_pkg::FullCircle : ang_a;
    ang_c = (ang_b >= p2s_pkg::HalfCircle) ? ang_b - p2s_pkg::FullCircle : ang_b;
    ang_neg = 1'b0;
    ang_d   = ang_c;
    if (ang_c > p2s_pkg::QuarterCircle) begin
      ang_d   = ang_c - p2s_pkg::HalfCircle;
      ang_neg = 1'b1;
    end else if (ang_c < -p2s_pkg::QuarterCircle) begin
      ang_d   = ang_c + p2s_pkg::HalfCircle;
      ang_neg = 1'b1;
    end
    in_dx = $signed({1'b0, s_tdata_i[19:0]}) - $signed({1'b0, cx_q});
    in_dy = $signed({1'b0, s_tdata_i[39:20]}) - $signed({1'b0, cy_q});
  end

  logic                    s0_vld_q;
  logic signed [AW-1:0]    s0_z_q;
  logic [RotSideW-1:0]     s0_side_q;

  // rotation CORDIC row
  logic                    rot_v    [Iters+1];
  logic signed [CW-1:0]    rot_x    [Iters+1];
  logic signed [CW-1:0]    rot_y    [Iters+1];
  logic signed [AW-1:0]    rot_z    [Iters+1];
  logic [RotSideW-1:0]     rot_side [Iters+1];

  assign rot_v[0]    = s0_vld_q;
  assign rot_x[0]    = p2s_pkg::CordGain;
  assign rot_y[0]    = '0;
  assign rot_z[0]    = s0_z_q;
  assign rot_side[0] = s0_side_q;

  for (genvar k = 0; k < Iters; k++) begin : g_rot
    p2s_cordic_cell #(.Iter(k), .SideW(RotSideW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(rot_v[k]), .x_i(rot_x[k]), .y_i(rot_y[k]), .z_i(rot_z[k]),
      .side_i(rot_side[k]),
      .valid_o(rot_v[k+1]), .x_o(rot_x[k+1]), .y_o(rot_y[k+1]), .z_o(rot_z[k+1]),
      .side_o(rot_side[k+1])
    );
  end

  logic signed [20:0] mul_dx, mul_dy;
  assign mul_dx = $signed(rot_side[Iters][41:21]);
  assign mul_dy = $signed(rot_side[Iters][20:0]);

  // rotation products, rounding, plate scale
  logic               m_vld_q, m_neg_q;
  logic signed [53:0] m_p1_q, m_p2_q, m_p3_q, m_p4_q;
  logic               r1_vld_q;
  logic signed [54:0] r1_a_q, r1_b_q;
  logic               r2_vld_q;
  logic signed [37:0] r2_ra_q, r2_de_q;
  logic               s1_vld_q;
  logic signed [61:0] s1_ra_q, s1_de_q;
  logic               s2_vld_q;
  logic [40:0]        s2_ra_q, s2_de_q;
  logic               s2_rsg_q, s2_dsg_q;

  logic signed [54:0] r1_sum_b, r2_rnd_a, r2_rnd_b;
  logic signed [62:0] s2_t_ra, s2_t_de;

  always_comb begin
    r1_sum_b = 55'(m_p3_q) + 55'(m_p4_q);
    r2_rnd_a = r1_a_q + Round14 - $signed({54'd0, r1_a_q[54]});
    r2_rnd_b = r1_b_q + Round14 - $signed({54'd0, r1_b_q[54]});
    s2_t_ra  = s1_ra_q[61] ? ScaleHalf - 63'(s1_ra_q) : ScaleHalf + 63'(s1_ra_q);
    s2_t_de  = s1_de_q[61] ? ScaleHalf - 63'(s1_de_q) : ScaleHalf + 63'(s1_de_q);
  end

  // divide by 225, both lanes: high part, remainder fold, low part
  logic        qa_vld_q, qb_vld_q, qc_vld_q;
  logic        qa_rsg_q, qa_dsg_q, qb_rsg_q, qb_dsg_q, qc_rsg_q, qc_dsg_q;
  logic [49:0] qa_ph_q [2];
  logic [20:0] qa_nh_q [2];
  logic [19:0] qa_nl_q [2];
  logic [13:0] qb_qh_q [2];
  logic [27:0] qb_x_q  [2];
  logic [13:0] qc_qh_q [2];
  logic [56:0] qc_pl_q [2];

  logic [40:0] qa_n   [2];
  logic [13:0] qb_qh  [2];
  logic [21:0] qb_rh  [2];
  logic [33:0] qc_quo [2];

  always_comb begin
    qa_n[0] = s2_ra_q;
    qa_n[1] = s2_de_q;
    for (int l = 0; l < 2; l++) begin
      qb_qh[l]  = qa_ph_q[l][49:36];
      qb_rh[l]  = 22'(qa_nh_q[l]) - 22'(qb_qh[l]) * Div225;
      qc_quo[l] = {qc_qh_q[l], qc_pl_q[l][55:36]};
    end
  end

  // declination offset and clamp, RA sign and clamp, pole test
  logic               f1_vld_q;
  logic signed [34:0] f1_dec_q;
  logic signed [32:0] f1_ra_q;
  logic               f2_vld_q;
  logic signed [AW-1:0] f2_z_q;
  logic [DecSideW-1:0]  f2_side_q;

  logic signed [34:0] f1_dec_d, f1_qd;
  logic               f1_rneg;
  logic [31:0]        f1_rmag;
  logic signed [32:0] f1_ra_d;
  logic               f2_pole;
  logic signed [34:0] f2_decs;

  always_comb begin
    f1_qd    = $signed({1'b0, qc_quo[1]});
    f1_dec_d = qc_dsg_q ? 35'($signed(tdec_q)) - f1_qd
                        : 35'($signed(tdec_q)) + f1_qd;
    f1_rneg  = qc_rsg_q ^ ~flip_q;
    f1_rmag  = (qc_quo[0] > 34'h080000000) ? 32'h80000000 : qc_quo[0][31:0];
    f1_ra_d  = f1_rneg ? -$signed({1'b0, f1_rmag}) : $signed({1'b0, f1_rmag});
    f2_pole  = !((f1_dec_q > -PoleLim) && (f1_dec_q < PoleLim));
    if (f1_dec_q > DecMax) begin
      f2_decs = DecMax;
    end else if (f1_dec_q < DecMin) begin
      f2_decs = DecMin;
    end else begin
      f2_decs = f1_dec_q;
    end
  end

  // declination CORDIC row
  logic                 dc_v    [Iters+1];
  logic signed [CW-1:0] dc_x    [Iters+1];
  logic signed [CW-1:0] dc_y    [Iters+1];
  logic signed [AW-1:0] dc_z    [Iters+1];
  logic [DecSideW-1:0]  dc_side [Iters+1];

  assign dc_v[0]    = f2_vld_q;
  assign dc_x[0]    = p2s_pkg::CordGain;
  assign dc_y[0]    = '0;
  assign dc_z[0]    = f2_z_q;
  assign dc_side[0] = f2_side_q;

  for (genvar k = 0; k < Iters; k++) begin : g_dec
    p2s_cordic_cell #(.Iter(k), .SideW(DecSideW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dc_v[k]), .x_i(dc_x[k]), .y_i(dc_y[k]), .z_i(dc_z[k]),
      .side_i(dc_side[k]),
      .valid_o(dc_v[k+1]), .x_o(dc_x[k+1]), .y_o(dc_y[k+1]), .z_o(dc_z[k+1]),
      .side_o(dc_side[k+1])
    );
  end

  // secant numerator
  logic                g1_vld_q;
  logic [31:0]         g1_cd_q, g1_rmag_q;
  logic [SecSideW-1:0] g1_side_q;
  logic                g2_vld_q;
  logic [31:0]         g2_cd_q;
  logic [61:0]         g2_num_q;
  logic [SecSideW-1:0] g2_side_q;

  logic signed [32:0] g1_ra;
  logic signed [32:0] g1_abs;
  logic [31:0]        g1_cd_d;

  always_comb begin
    g1_ra   = $signed(dc_side[Iters][64:32]);
    g1_abs  = g1_ra[32] ? -g1_ra : g1_ra;
    g1_cd_d = (dc_x[Iters] < 33'sd1) ? 32'd1 : dc_x[Iters][31:0];
  end

  // secant division
  logic                dbv    [DivBN+1];
  logic [31:0]         db_div [DivBN+1];
  logic [31:0]         db_rem [DivBN+1][1];
  logic [DivBN-1:0]    db_num [DivBN+1][1];
  logic [DivBN-1:0]    db_quo [DivBN+1][1];
  logic [SecSideW-1:0] db_side[DivBN+1];

  assign dbv[0]       = g2_vld_q;
  assign db_div[0]    = g2_cd_q;
  assign db_rem[0][0] = {8'd0, g2_num_q[61:38]};
  assign db_num[0][0] = g2_num_q[37:0];
  assign db_quo[0][0] = '0;
  assign db_side[0]   = g2_side_q;

  for (genvar k = 0; k < DivBN; k++) begin : g_divb
    p2s_div_cell #(
      .Lanes(1), .DivW(32), .NumW(DivBN), .QuoW(DivBN), .SideW(SecSideW)
    ) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dbv[k]), .div_i(db_div[k]), .rem_i(db_rem[k]), .num_i(db_num[k]),
      .quo_i(db_quo[k]), .side_i(db_side[k]),
      .valid_o(dbv[k+1]), .div_o(db_div[k+1]), .rem_o(db_rem[k+1]),
      .num_o(db_num[k+1]), .quo_o(db_quo[k+1]), .side_o(db_side[k+1])
    );
  end

  // final RA select, center RA, saturation
  logic               h1_vld_q;
  logic signed [39:0] h1_ra_q;
  logic [30:0]        h1_dec_q;
  logic               h1_pole_q;
  logic               out_vld_q;
  logic [30:0]        out_ra_q, out_dec_q;
  logic               out_pole_q;

  logic signed [39:0] h1_q, h1_ra_d;
  logic signed [40:0] o_sum;
  logic signed [40:0] o_sat;

  always_comb begin
    h1_q    = $signed({2'b00, db_quo[DivBN][0]});
    h1_ra_d = db_side[DivBN][1] ? 40'($signed(db_side[DivBN][65:33]))
                                : (db_side[DivBN][0] ? -h1_q : h1_q);
    o_sum   = 41'(h1_ra_q) + $signed({12'd0, tra_q});
    if (o_sum > OutMax) begin
      o_sat = OutMax;
    end else if (o_sum < OutMin) begin
      o_sat = OutMin;
    end else begin
      o_sat = o_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      m_vld_q   <= 1'b0;
      r1_vld_q  <= 1'b0;
      r2_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      qa_vld_q  <= 1'b0;
      qb_vld_q  <= 1'b0;
      qc_vld_q  <= 1'b0;
      f1_vld_q  <= 1'b0;
      f2_vld_q  <= 1'b0;
      g1_vld_q  <= 1'b0;
      g2_vld_q  <= 1'b0;
      h1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q  <= acc;
      m_vld_q   <= rot_v[Iters];
      r1_vld_q  <= m_vld_q;
      r2_vld_q  <= r1_vld_q;
      s1_vld_q  <= r2_vld_q;
      s2_vld_q  <= s1_vld_q;
      qa_vld_q  <= s2_vld_q;
      qb_vld_q  <= qa_vld_q;
      qc_vld_q  <= qb_vld_q;
      f1_vld_q  <= qc_vld_q;
      f2_vld_q  <= f1_vld_q;
      g1_vld_q  <= dc_v[Iters];
      g2_vld_q  <= g1_vld_q;
      h1_vld_q  <= dbv[DivBN];
      out_vld_q <= h1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_z_q    <= {ang_d[24:0], 4'b0000};
      s0_side_q <= {ang_neg, in_dx, in_dy};

      m_neg_q <= rot_side[Iters][42];
      m_p1_q  <= 54'(rot_x[Iters]) * 54'(mul_dx);
      m_p2_q  <= 54'(rot_y[Iters]) * 54'(mul_dy);
      m_p3_q  <= 54'(rot_x[Iters]) * 54'(mul_dy);
      m_p4_q  <= 54'(rot_y[Iters]) * 54'(mul_dx);

      r1_a_q <= m_neg_q ? 55'(m_p2_q) - 55'(m_p1_q) : 55'(m_p1_q) - 55'(m_p2_q);
      r1_b_q <= m_neg_q ? -r1_sum_b : r1_sum_b;

      r2_ra_q <= r2_rnd_a[51:14];
      r2_de_q <= r2_rnd_b[51:14];

      s1_ra_q <= 62'(r2_ra_q) * 62'($signed(scx_q));
      s1_de_q <= 62'(r2_de_q) * 62'($signed(scy_q));

      s2_ra_q  <= s2_t_ra[60:20];
      s2_de_q  <= s2_t_de[60:20];
      s2_rsg_q <= s1_ra_q[61];
      s2_dsg_q <= s1_de_q[61];

      qa_rsg_q <= s2_rsg_q;
      qa_dsg_q <= s2_dsg_q;
      qb_rsg_q <= qa_rsg_q;
      qb_dsg_q <= qa_dsg_q;
      qc_rsg_q <= qb_rsg_q;
      qc_dsg_q <= qb_dsg_q;
      for (int l = 0; l < 2; l++) begin
        qa_ph_q[l] <= 50'(qa_n[l][40:20]) * 50'(Recip225);
        qa_nh_q[l] <= qa_n[l][40:20];
        qa_nl_q[l] <= qa_n[l][19:0];
        qb_qh_q[l] <= qb_qh[l];
        qb_x_q[l]  <= {qb_rh[l][7:0], qa_nl_q[l]};
        qc_qh_q[l] <= qb_qh_q[l];
        qc_pl_q[l] <= 57'(qb_x_q[l]) * 57'(Recip225);
      end

      f1_dec_q <= f1_dec_d;
      f1_ra_q  <= f1_ra_d;

      f2_z_q    <= f1_dec_q[AW-1:0];
      f2_side_q <= {f1_ra_q, f2_decs[30:0], f2_pole};

      g1_cd_q   <= g1_cd_d;
      g1_rmag_q <= g1_abs[31:0];
      g1_side_q <= {dc_side[Iters], g1_ra[32]};

      g2_cd_q   <= g1_cd_q;
      g2_num_q  <= {g1_rmag_q, 30'd0} + {31'd0, g1_cd_q[31:1]};
      g2_side_q <= g1_side_q;

      h1_ra_q   <= h1_ra_d;
      h1_dec_q  <= db_side[DivBN][32:2];
      h1_pole_q <= db_side[DivBN][1];

      out_ra_q   <= o_sat[30:0];
      out_dec_q  <= h1_dec_q;
      out_pole_q <= h1_pole_q;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {2'b00, out_dec_q, out_ra_q};
  assign m_tuser_o  = out_pole_q;

endmodule

// ===== hw/rtl/p2s_checker.sv =====
// Port-level checks of the plate transform, bound to the top level.
module p2s_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_o,
  input logic [39:0] s_tdata_i,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [63:0] m_tdata_o,
  input logic        m_tuser_o,
  input logic        cfg_we_i,
  input logic [2:0]  cfg_idx_i,
  input logic [28:0] cfg_data_i
);

  logic signed [30:0] dec_w;
  logic signed [30:0] lim_w;
  assign dec_w = $signed(m_tdata_o[61:31]);
  assign lim_w = 31'(p2s_pkg::PoleLimit);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("held result beat changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o == (!m_tvalid_o || m_tready_i))
    else $error("input ready does not follow output stall");

  a_pole_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (dec_w >= lim_w || dec_w <= -lim_w) |-> m_tuser_o)
    else $error("near_pole clear at polar declination");

  a_pole_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> (dec_w >= lim_w || dec_w <= -lim_w))
    else $error("near_pole set away from pole");

  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> m_tvalid_o)
    else $error("input stalled with no result waiting");

endmodule

bind pixel_to_sky_coordinates_unit p2s_checker u_p2s_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the pixel to sky plate transform pipeline.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 93;
  localparam int StallLimit = 20000;

  typedef struct packed {
    logic [30:0] ra;
    logic [30:0] dec;
    logic        pole;
  } sky_pos_t;

  class sky_scoreboard;
    sky_pos_t pending[$];
    int errors;
    logic [19:0] cx, cy;
    logic [24:0] rot;
    logic [23:0] sx, sy;
    logic [28:0] tra;
    logic [27:0] tdec;
    logic        flip;

    function new();
      errors = 0;
      cx = '0; cy = '0; rot = '0; sx = 24'd65536; sy = 24'd65536;
      tra = '0; tdec = '0; flip = 1'b0;
    endfunction

    function void write_reg(p2s_pkg::cfg_reg_e idx, logic [28:0] v);
      case (idx)
        p2s_pkg::RegCenterX:  cx = v[19:0];
        p2s_pkg::RegCenterY:  cy = v[19:0];
        p2s_pkg::RegRotation: rot = v[24:0];
        p2s_pkg::RegScaleX:   sx = v[23:0];
        p2s_pkg::RegScaleY:   sy = v[23:0];
        p2s_pkg::RegTargetRa: tra = v[28:0];
        p2s_pkg::RegTargetDe: tdec = v[27:0];
        default:              flip = v[0];
      endcase
    endfunction

    function longint round_div(longint num, longint den);
      longint m;
      m = (num < 0) ? -num : num;
      m = (m + den / 2) / den;
      return (num < 0) ? -m : m;
    endfunction

    function void rotate(longint z, output longint c, output longint s);
      longint x, y, xs, ys;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 20; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= longint'(p2s_pkg::atan_q20(i));
        end else begin
          x += ys; y -= xs; z += longint'(p2s_pkg::atan_q20(i));
        end
      end
      c = x;
      s = y;
    endfunction

    function sky_pos_t transform(logic [19:0] px, logic [19:0] py);
      longint dx, dy, a, c, s, rp, dp, ra, dec, cd, sd;
      bit neg, pole;
      sky_pos_t r;
      dx = longint'(px) - longint'(cx);
      dy = longint'(py) - longint'(cy);
      a = longint'($signed(rot));
      neg = 0;
      if (a < 0) a += 23592960;
      if (a >= 11796480) a -= 23592960;
      if (a > 5898240) begin
        a -= 11796480; neg = 1;
      end else if (a < -5898240) begin
        a += 11796480; neg = 1;
      end
      rotate(a * 16, c, s);
      if (neg) begin
        c = -c; s = -s;
      end
      rp = round_div(c * dx - s * dy, 16384);
      dp = round_div(c * dy + s * dx, 16384);
      dec = round_div(dp * longint'($signed(sy)), 235929600) + longint'($signed(tdec));
      ra = round_div(rp * longint'($signed(sx)), 235929600);
      if (!flip) ra = -ra;
      if (ra > 64'sd2147483648) ra = 64'sd2147483648;
      if (ra < -64'sd2147483648) ra = -64'sd2147483648;
      pole = !(dec > -p2s_pkg::PoleLimit && dec < p2s_pkg::PoleLimit);
      if (!pole) begin
        rotate(dec, cd, sd);
        if (cd < 1) cd = 1;
        ra = round_div(ra * (64'sd1 <<< 30), cd);
      end
      ra += longint'(tra);
      if (ra > 1073741823) ra = 1073741823;
      if (ra < -1073741824) ra = -1073741824;
      if (dec > 1073741823) dec = 1073741823;
      if (dec < -1073741824) dec = -1073741824;
      r.ra = ra[30:0];
      r.dec = dec[30:0];
      r.pole = pole;
      return r;
    endfunction

    function void note_pixel(logic [39:0] d);
      pending.push_back(transform(d[19:0], d[39:20]));
    endfunction

    function void check_sky(logic [63:0] d, logic u);
      sky_pos_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat ra=%h dec=%h pole=%b", $time, d[30:0], d[61:31], u);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[30:0] !== e.ra) begin
        $display("%0t: sky_ra expected %h actual %h", $time, e.ra, d[30:0]);
        errors++;
      end
      if (d[61:31] !== e.dec) begin
        $display("%0t: sky_dec expected %h actual %h", $time, e.dec, d[61:31]);
        errors++;
      end
      if (u !== e.pole) begin
        $display("%0t: near_pole expected %b actual %b", $time, e.pole, u);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_tvalid_i = 0, m_tready_i = 0, cfg_we_i = 0;
  logic s_tready_o, m_tvalid_o, m_tuser_o;
  logic [39:0] s_tdata_i = '0;
  logic [63:0] m_tdata_o;
  logic [2:0] cfg_idx_i = '0;
  logic [28:0] cfg_data_i = '0;

  sky_scoreboard sb = new();
  int idle_cycles = 0;
  bit hold_off = 0, timed_out = 0;
  int rx_mode = 0;

  pixel_to_sky_coordinates_unit u_dut (.*);

  initial forever #6 clk_i = ~clk_i;

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) sb.note_pixel(s_tdata_i);
      if (m_tvalid_o && m_tready_i) sb.check_sky(m_tdata_o, m_tuser_o);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles > StallLimit && !timed_out) begin
      timed_out = 1;
      $display("pixel_to_sky_coordinates_unit regression: fail");
      $finish;
    end
  end

  initial begin : receiver
    int g;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        m_tready_i <= 0;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      g = (rx_mode == 0) ? 0 : gap_len();
      if (g > 0) begin
        m_tready_i <= 0;
        repeat (g) @(posedge clk_i);
      end
      m_tready_i <= 1;
      @(posedge clk_i);
      if ($urandom_range(0, 99) == 0) rx_mode = $urandom_range(0, 1);
    end
  end

  task automatic send_pixel(logic [19:0] px, logic [19:0] py, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_tvalid_i <= 1;
    s_tdata_i <= {py, px};
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  task automatic end_burst();
    s_tvalid_i <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic write_cfg(p2s_pkg::cfg_reg_e idx, logic [28:0] v);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic [28:0] rand_reg(p2s_pkg::cfg_reg_e idx);
    int sel;
    sel = $urandom_range(0, 3);
    case (idx)
      p2s_pkg::RegCenterX, p2s_pkg::RegCenterY:
        return sel == 0 ? 29'd0 : sel == 1 ? 29'hFFFFF : 29'($urandom_range(0, 1048575));
      p2s_pkg::RegRotation:
        return sel == 0 ? 29'(-25'sd11796480) : sel == 1 ? 29'(25'sd11796480)
             : 29'($urandom_range(0, 25'h1FFFFFF));
      p2s_pkg::RegScaleX, p2s_pkg::RegScaleY:
        return sel == 0 ? 29'h800000 : sel == 1 ? 29'h7FFFFF
             : 29'($urandom_range(0, 24'hFFFFFF));
      p2s_pkg::RegTargetRa:
        return sel == 0 ? 29'd0 : sel == 1 ? 29'd377487360 : 29'($urandom_range(0, 377487360));
      p2s_pkg::RegTargetDe:
        return sel == 0 ? 29'(-28'sd94371840) : sel == 1 ? 29'(28'sd94371840)
             : 29'($urandom_range(0, 28'hFFFFFFF));
      default:
        return 29'($urandom_range(0, 1));
    endcase
  endfunction

  initial begin : stimulus
    logic [19:0] ex [4] = '{20'd0, 20'hFFFFF, 20'd1, 20'h80000};
    int n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    foreach (ex[i]) foreach (ex[j]) send_pixel(ex[i], ex[j], 0);
    end_burst();
    write_cfg(p2s_pkg::RegCenterX, 29'h80000);
    write_cfg(p2s_pkg::RegCenterY, 29'h80000);
    write_cfg(p2s_pkg::RegRotation, 29'(25'sd11796480 + 25'sd5898240));
    write_cfg(p2s_pkg::RegScaleX, 29'h7FFFFF);
    write_cfg(p2s_pkg::RegScaleY, 29'h800000);
    write_cfg(p2s_pkg::RegTargetRa, 29'd377487360);
    write_cfg(p2s_pkg::RegTargetDe, 29'(28'sd93323264));
    write_cfg(p2s_pkg::RegFlip, 29'd1);
    foreach (ex[i]) send_pixel(ex[i], ex[3 - i], 1);
    end_burst();
    write_cfg(p2s_pkg::RegScaleY, 29'd65536);
    write_cfg(p2s_pkg::RegTargetDe, 29'(-28'sd93323264));
    foreach (ex[i]) send_pixel(ex[i], ex[i], 1);
    end_burst();

    hold_off = 1;
    for (int k = 0; k < 200; k++)
      send_pixel(20'($urandom_range(0, 1048575)), 20'($urandom_range(0, 1048575)), 0);
    end_burst();

    for (int ph = 0; ph < 12; ph++) begin
      for (int r = 0; r < 8; r++)
        if (ph == 0 || $urandom_range(0, 1))
          write_cfg(p2s_pkg::cfg_reg_e'(r), rand_reg(p2s_pkg::cfg_reg_e'(r)));
      n = $urandom_range(30, 70);
      for (int k = 0; k < n; k++)
        send_pixel(20'($urandom_range(0, 1048575)), 20'($urandom_range(0, 1048575)),
                   ph % 3 != 0);
      end_burst();
    end

    if (sb.errors == 0)
      $display("pixel_to_sky_coordinates_unit regression: pass");
    else
      $display("pixel_to_sky_coordinates_unit regression: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/p2s_pkg.sv
hw/rtl/p2s_cordic_cell.sv
hw/rtl/p2s_div_cell.sv
hw/rtl/pixel_to_sky_coordinates_unit.sv
hw/rtl/p2s_checker.sv
tb/testbench.sv
